// ----- rtl/mmg_pkg.sv -----
// ============================================================================
// mmg_pkg: shared definitions for the min-max gray normalizer
// Widths, defaults, status codes, register indexes and the divider handoff.
// ============================================================================
package mmg_pkg;

    localparam int MAX_PIXELS_DEF  = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ELEV_W   = 16;   // input sample field
    localparam int DIM_W    = 9;    // row_count / col_count
    localparam int TOTAL_W  = 2 * DIM_W;
    localparam int SHADE_W  = 8;    // gray scale is 2**SHADE_W - 1 = 255
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_PIXEL    = 2'd0,
        ST_LOAD_OK  = 2'd1,
        ST_LOAD_ERR = 2'd2,
        ST_NO_IMAGE = 2'd3
    } status_t;

    // divider result handed back to the sequencer
    typedef struct packed {
        logic               done;
        logic [SHADE_W-1:0] shade;
    } mmg_div_res_t;

endpackage

// ----- rtl/mmg_shade_div.sv -----
// ============================================================================
// mmg_shade_div: iterative shade divider
// Computes round((v-min)*255/(max-min)) with a restoring divider, one
// quotient bit per cycle; flat inputs or samples below min give shade 0.
// ============================================================================
module mmg_shade_div #(
    parameter int SAMPLE_BITS = mmg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] min_val,
    input  logic signed [SAMPLE_BITS-1:0] max_val,
    output mmg_pkg::mmg_div_res_t         res
);
    import mmg_pkg::*;

    localparam int DW     = SAMPLE_BITS + 1;
    localparam int RW     = SAMPLE_BITS + SHADE_W + 3;
    localparam int STEP_W = $clog2(SHADE_W);

    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] den;
    logic                 flat;
    logic [RW-1:0]        diff_w;
    logic [RW-1:0]        den_w;
    logic [RW-1:0]        num255;
    logic [RW-1:0]        rem_init;
    logic [RW-1:0]        dvs_init;
    logic                 ge;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [RW-1:0]        dvs_reg, dvs_next;
    logic [SHADE_W-1:0]   q_reg, q_next;

    always_comb
    begin
        diff   = DW'(sample) - DW'(min_val);
        den    = DW'(max_val) - DW'(min_val);
        flat   = den[DW-1] || (den == '0) || diff[DW-1];
        diff_w = RW'($unsigned(diff));
        den_w  = RW'($unsigned(den));
        // x*255 = (x << 8) - x
        num255   = (diff_w << SHADE_W) - diff_w;
        // (2*num + den) / (2*den); divisor starts at top quotient bit
        rem_init = (num255 << 1) + den_w;
        dvs_init = den_w << SHADE_W;
        ge       = (rem_reg >= dvs_reg);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start)
        begin
            q_next    = '0;
            rem_next  = rem_init;
            dvs_next  = dvs_init;
            step_next = STEP_W'(SHADE_W - 1);
            if (flat)
            begin
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dvs_reg;
            end
            q_next    = {q_reg[SHADE_W-2:0], ge};
            dvs_next  = dvs_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign res.done  = done_reg;
    assign res.shade = q_reg;

endmodule

// ----- rtl/minmax_normalize_to_gray_top.sv -----
// ============================================================================
// minmax_normalize_to_gray_top: min-max contrast stretch to 8-bit gray
// Loads signed samples into an on-chip store while tracking min and max,
// then reads pixels back in load order as rounded 8-bit shades.
// ============================================================================
// Result path: closing samples and no-image reads go via S_DONE to out_valid;
//   pixel reads pass store read, divider load, 8 steps, done and hand-off.
// Flow: one item in flight; each of those holds in_ready low until its result
//   is in the output register; other load samples are taken back to back.
// Reset: rst_n async low clears control, counts, min/max and image status;
//   registers go to 1; the sample store is not cleared and needs no sweep.
module minmax_normalize_to_gray_top #(
    parameter int MAX_PIXELS  = mmg_pkg::MAX_PIXELS_DEF,
    parameter int SAMPLE_BITS = mmg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input item channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic signed [mmg_pkg::ELEV_W-1:0] elevation,
    input  logic                              last_value,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mmg_pkg::SHADE_W-1:0]       shade,
    output logic                              last_pixel,
    output logic [1:0]                        status,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mmg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mmg_pkg::DIM_W-1:0]         cfg_data
);
    import mmg_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW    = $clog2(MAX_PIXELS + 2);      // holds MAX_PIXELS + 1
    localparam int CMPW  = (CW > TOTAL_W) ? CW : TOTAL_W;
    localparam int EXT_W = (SB > ELEV_W) ? SB : ELEV_W;

    // one-hot sequencer
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]     row_count_reg, row_count_next;
    logic [DIM_W-1:0]     col_count_reg, col_count_next;
    logic signed [SB-1:0] min_reg, min_next;
    logic signed [SB-1:0] max_reg, max_next;
    logic [CW-1:0]        load_count_reg, load_count_next;
    logic [AW-1:0]        read_index_reg, read_index_next;
    logic                 image_ready_reg, image_ready_next;

    // pending result, then the output register
    logic [SHADE_W-1:0]   res_shade_reg, res_shade_next;
    logic                 res_last_reg, res_last_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SHADE_W-1:0]   shade_reg, shade_next;
    logic                 last_pixel_reg, last_pixel_next;
    status_t              status_reg, status_next;

    // sample store
    logic [SB-1:0]        mem [MAX_PIXELS];
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 rd_en;
    logic [SB-1:0]        rd_data_reg;

    logic signed [EXT_W-1:0] elev_ext;
    logic signed [SB-1:0]    sample;
    logic signed [SB-1:0]    min_base;
    logic signed [SB-1:0]    max_base;
    logic [CW-1:0]           count_inc;
    logic [TOTAL_W-1:0]      total;
    logic [CMPW-1:0]         total_c;
    logic [CMPW-1:0]         count_c;
    logic [CMPW-1:0]         index_c;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    store_room;
    logic                    read_bad;
    logic                    div_start;
    mmg_div_res_t            div_res;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid_reg && out_ready;

    // sample cut to SAMPLE_BITS and read back signed
    assign elev_ext = EXT_W'(elevation);
    assign sample   = elev_ext[SB-1:0];

    assign total   = TOTAL_W'(row_count_reg) * TOTAL_W'(col_count_reg);
    assign total_c = CMPW'(total);
    assign index_c = CMPW'(read_index_reg);

    // --------------------------------------------------------------------
    // configuration registers
    // --------------------------------------------------------------------
    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_COUNT: row_count_next = cfg_data;
                REG_COL_COUNT: col_count_next = cfg_data;
                default:       ;
            endcase
        end
    end

    // --------------------------------------------------------------------
    // sequencer
    // --------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        load_count_next  = load_count_reg;
        read_index_next  = read_index_reg;
        image_ready_next = image_ready_reg;
        res_shade_next   = res_shade_reg;
        res_last_next    = res_last_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        shade_next       = shade_reg;
        last_pixel_next  = last_pixel_reg;
        status_next      = status_reg;
        wr_en            = 1'b0;
        wr_addr          = load_count_reg[AW-1:0];
        rd_en            = 1'b0;
        div_start        = 1'b0;

        // first sample of a load seeds min/max
        min_base   = (load_count_reg == '0) ? sample : min_reg;
        max_base   = (load_count_reg == '0) ? sample : max_reg;
        store_room = (load_count_reg < CW'(MAX_PIXELS));
        count_inc  = store_room ? (load_count_reg + CW'(1)) : CW'(MAX_PIXELS + 1);
        count_c    = CMPW'(count_inc);
        read_bad   = !image_ready_reg || (total == '0) ||
                     (total_c > CMPW'(MAX_PIXELS)) || (index_c >= total_c);

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && !mode)
                begin
                    if (load_count_reg == '0)
                    begin
                        image_ready_next = 1'b0;
                        read_index_next  = '0;
                    end
                    min_next = min_base;
                    max_next = max_base;
                    if (store_room)
                    begin
                        wr_en = 1'b1;
                        if (sample < min_base)
                        begin
                            min_next = sample;
                        end
                        if (sample > max_base)
                        begin
                            max_next = sample;
                        end
                    end
                    load_count_next = count_inc;
                    if (last_value)
                    begin
                        // closing sample: count must match the grid
                        if ((count_c <= CMPW'(MAX_PIXELS)) && (count_c == total_c))
                        begin
                            image_ready_next = 1'b1;
                            res_status_next  = ST_LOAD_OK;
                        end
                        else
                        begin
                            image_ready_next = 1'b0;
                            res_status_next  = ST_LOAD_ERR;
                        end
                        res_shade_next  = '0;
                        res_last_next   = 1'b0;
                        read_index_next = '0;
                        load_count_next = '0;
                        state_next      = S_DONE;
                    end
                end
                else if (in_xfer)
                begin
                    res_shade_next = '0;
                    res_last_next  = 1'b0;
                    if (read_bad)
                    begin
                        res_status_next = ST_NO_IMAGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        rd_en           = 1'b1;
                        res_status_next = ST_PIXEL;
                        if (index_c == total_c - CMPW'(1))
                        begin
                            res_last_next   = 1'b1;
                            read_index_next = '0;
                        end
                        else
                        begin
                            read_index_next = read_index_reg + AW'(1);
                        end
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_res.done)
                begin
                    res_shade_next = div_res.shade;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    shade_next      = res_shade_reg;
                    last_pixel_next = res_last_reg;
                    status_next     = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            row_count_reg   <= DIM_RESET;
            col_count_reg   <= DIM_RESET;
            min_reg         <= '0;
            max_reg         <= '0;
            load_count_reg  <= '0;
            read_index_reg  <= '0;
            image_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_count_reg   <= row_count_next;
            col_count_reg   <= col_count_next;
            min_reg         <= min_next;
            max_reg         <= max_next;
            load_count_reg  <= load_count_next;
            read_index_reg  <= read_index_next;
            image_ready_reg <= image_ready_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_shade_reg  <= res_shade_next;
        res_last_reg   <= res_last_next;
        res_status_reg <= res_status_next;
        shade_reg      <= shade_next;
        last_pixel_reg <= last_pixel_next;
        status_reg     <= status_next;
    end

    // sample store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[read_index_reg];
        end
    end

    // --------------------------------------------------------------------
    // shared divider
    // --------------------------------------------------------------------
    mmg_shade_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .sample  (rd_data_reg),
        .min_val (min_reg),
        .max_val (max_reg),
        .res     (div_res)
    );

    assign out_valid  = out_valid_reg;
    assign shade      = shade_reg;
    assign last_pixel = last_pixel_reg;
    assign status     = status_reg;

    // --------------------------------------------------------------------
    // assertions
    // --------------------------------------------------------------------
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_WAIT))
        else $error("divider finished outside wait state");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result appeared without a hand-off");

    a_ready_means_closed: assert property (@(posedge clk) disable iff (!rst_n)
        image_ready_reg |-> (load_count_reg == '0))
        else $error("image marked ready during a load");

    a_status_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_PIXEL)) |->
            ((shade_reg == '0) && !last_pixel_reg))
        else $error("status result carries pixel data");

endmodule
